// ----- hw/rtl/cfrem_pkg.sv -----
// ----------------------------------------------------------------------------
// cfrem_pkg - shared types and constants of the CAN frame rule edge matcher
// Request/result payload structs, write bus, the token handed between rule
// cells, and sizing constants.
// ----------------------------------------------------------------------------
package cfrem_pkg;

  localparam int RULES = 16;
  localparam int CONDS = 4;

  localparam int RIDX_W     = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int NCNT_W     = $clog2(RULES + 1);
  localparam int CCNT_W     = $clog2(CONDS + 1);
  localparam int SLOT_CMP_W = (RIDX_W > 4) ? RIDX_W : 4;
  localparam int RCNT_CMP_W = (NCNT_W > 5) ? NCNT_W : 5;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [3:0]  MAX_LEN       = 4'd8;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_HDR   = 2'd1;
  localparam logic [1:0] OP_COND  = 2'd2;
  localparam logic [1:0] OP_POLL  = 2'd3;

  localparam logic [1:0] CFG_RULE_COUNT = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [28:0] frame_id;
    logic        extended;
    logic [3:0]  length;
    logic [63:0] payload;
    logic [31:0] now_ms;
    logic [3:0]  rule_slot;
    logic [1:0]  cond_slot;
    logic [3:0]  cond_byte;
    logic [7:0]  cond_mask;
    logic [7:0]  cond_value;
    logic        falling_edge;
  } req_t;

  typedef struct packed {
    logic        engaged;
    logic        event_valid;
    logic [3:0]  event_rule;
    logic [15:0] match_states;
  } res_t;

  typedef struct packed {
    logic [3:0] pos;
    logic [7:0] mask;
    logic [7:0] value;
  } cond_t;

  typedef struct packed {
    logic              hdr_en;
    logic              cond_en;
    logic [3:0]        rule_slot;
    logic [1:0]        cond_slot;
    logic [28:0]       ident;
    logic              ext;
    logic              pol;
    logic [CCNT_W-1:0] count;
    cond_t             cond;
  } wr_t;

  typedef struct packed {
    logic              valid;
    logic              is_poll;
    logic [28:0]       id;
    logic              ext;
    logic [3:0]        len;
    logic [63:0]       payload;
    logic [NCNT_W-1:0] n;
    logic              rise;
    logic              found;
    logic [RIDX_W-1:0] found_rule;
  } tok_t;

endpackage

// ----- hw/rtl/cfrem_rule_cell.sv -----
// ----------------------------------------------------------------------------
// cfrem_rule_cell - one rule slot of the matcher chain
// Holds one rule and its match/event flags, evaluates the passing frame or
// poll token and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module cfrem_rule_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cfrem_pkg::RIDX_W-1:0] cell_index,
  input  cfrem_pkg::wr_t              wr,
  input  cfrem_pkg::tok_t             tok_in,
  output cfrem_pkg::tok_t             tok_out,
  output logic                        matched
);

  logic [28:0]                  ident;
  logic                         ext;
  logic                         pol;
  logic [cfrem_pkg::CCNT_W-1:0] cnt;
  cfrem_pkg::cond_t             conds [cfrem_pkg::CONDS];
  logic                         event_flag;

  logic            sel;
  logic            active;
  logic            hit;
  logic            holds;
  logic            poll_take;
  logic            rise_here;
  logic            fall_here;
  cfrem_pkg::tok_t tok_next;

  assign sel = ({{(cfrem_pkg::SLOT_CMP_W - 4){1'b0}}, wr.rule_slot} ==
                cfrem_pkg::SLOT_CMP_W'(cell_index));

  always_comb begin
    logic [7:0] b;
    holds = 1'b1;
    for (int c = 0; c < cfrem_pkg::CONDS; c++) begin
      b = tok_in.payload[{conds[c].pos[2:0], 3'b000} +: 8];
      if (cfrem_pkg::CCNT_W'(c) < cnt) begin
        if (conds[c].pos >= tok_in.len || (b & conds[c].mask) != conds[c].value) begin
          holds = 1'b0;
        end
      end
    end
  end

  assign active    = tok_in.valid &&
                     (cfrem_pkg::NCNT_W'(cell_index) < tok_in.n);
  assign hit       = active && !tok_in.is_poll && ident == tok_in.id && ext == tok_in.ext;
  assign rise_here = hit && !pol && !matched && holds;
  assign fall_here = hit && pol && matched && !holds;
  assign poll_take = active && tok_in.is_poll && !tok_in.found && event_flag;

  always_comb begin
    tok_next = tok_in;
    if (rise_here) begin
      tok_next.rise = 1'b1;
    end
    if (poll_take) begin
      tok_next.found      = 1'b1;
      tok_next.found_rule = cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.hdr_en && sel) begin
      ident <= wr.ident;
      ext   <= wr.ext;
      pol   <= wr.pol;
      cnt   <= wr.count;
    end
    for (int c = 0; c < cfrem_pkg::CONDS; c++) begin
      if (wr.cond_en && sel && {2'b00, wr.cond_slot} == 4'(c)) begin
        conds[c] <= wr.cond;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matched       <= 1'b0;
      event_flag    <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (wr.hdr_en && sel) begin
        matched    <= 1'b0;
        event_flag <= 1'b0;
      end else begin
        if (hit) begin
          matched <= holds;
        end
        if (rise_here || fall_here) begin
          event_flag <= 1'b1;
        end else if (poll_take) begin
          event_flag <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/can_frame_rule_edge_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// can_frame_rule_edge_matcher_unit - CAN rule table with edge events
// Frame and poll requests walk a chain of rule cells, one cell per cycle;
// rule writes go straight to the addressed cell.
// Flow: a frame/poll token passes through all RULES cells, then the FSM moves
// to finish and registers the result once the output is free; writes go straight to finish.
// Throughput: one request at a time; the next is taken the cycle after the
// result is loaded.
// Reset: rst clears all match/event flags, engaged, deadline, rule count
// and sets the engage timeout to 5000 ms; rule contents stay unwritten.
// ----------------------------------------------------------------------------
module can_frame_rule_edge_matcher_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  cfrem_pkg::req_t req_data,
  output logic            res_valid,
  input  logic            res_ready,
  output cfrem_pkg::res_t res_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [4:0]  rule_count;
  logic [15:0] timeout;
  logic        engaged;
  logic [31:0] deadline;
  logic [31:0] now_hold;
  logic        ev_valid;
  logic [cfrem_pkg::RIDX_W-1:0] ev_rule;

  logic                         accept;
  logic [cfrem_pkg::NCNT_W-1:0] n_active;
  cfrem_pkg::wr_t               wr;
  cfrem_pkg::tok_t              tok_link [cfrem_pkg::RULES + 1];
  logic [cfrem_pkg::RULES-1:0]  matched;
  logic [cfrem_pkg::RULES-1:0]  tok_busy;
  cfrem_pkg::tok_t              last;
  logic [31:0]                  dl_new;
  logic                         eng_new;
  logic [15:0]                  states;
  logic                         load;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  assign n_active = (cfrem_pkg::RCNT_CMP_W'(rule_count) >
                     cfrem_pkg::RCNT_CMP_W'(cfrem_pkg::RULES)) ?
                    cfrem_pkg::NCNT_W'(cfrem_pkg::RULES) :
                    cfrem_pkg::NCNT_W'(rule_count);

  always_comb begin
    wr.hdr_en     = accept && req_data.opcode == cfrem_pkg::OP_HDR;
    wr.cond_en    = accept && req_data.opcode == cfrem_pkg::OP_COND;
    wr.rule_slot  = req_data.rule_slot;
    wr.cond_slot  = req_data.cond_slot;
    wr.ident      = req_data.frame_id;
    wr.ext        = req_data.extended;
    wr.pol        = req_data.falling_edge;
    wr.count      = (req_data.length > 4'(cfrem_pkg::CONDS)) ?
                    cfrem_pkg::CCNT_W'(cfrem_pkg::CONDS) :
                    cfrem_pkg::CCNT_W'(req_data.length);
    wr.cond.pos   = req_data.cond_byte;
    wr.cond.mask  = req_data.cond_mask;
    wr.cond.value = req_data.cond_value;
  end

  always_comb begin
    tok_link[0].valid      = accept && (req_data.opcode == cfrem_pkg::OP_FRAME ||
                                        req_data.opcode == cfrem_pkg::OP_POLL);
    tok_link[0].is_poll    = req_data.opcode == cfrem_pkg::OP_POLL;
    tok_link[0].id         = req_data.frame_id;
    tok_link[0].ext        = req_data.extended;
    tok_link[0].len        = (req_data.length > cfrem_pkg::MAX_LEN) ?
                             cfrem_pkg::MAX_LEN : req_data.length;
    tok_link[0].payload    = req_data.payload;
    tok_link[0].n          = n_active;
    tok_link[0].rise       = 1'b0;
    tok_link[0].found      = 1'b0;
    tok_link[0].found_rule = '0;
  end

  for (genvar i = 0; i < cfrem_pkg::RULES; i++) begin : g_cell
    cfrem_rule_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (cfrem_pkg::RIDX_W'(i)),
      .wr         (wr),
      .tok_in     (tok_link[i]),
      .tok_out    (tok_link[i+1]),
      .matched    (matched[i])
    );
    assign tok_busy[i] = tok_link[i+1].valid;
  end

  for (genvar i = 0; i < 16; i++) begin : g_states
    if (i < cfrem_pkg::RULES) begin : g_on
      assign states[i] = matched[i];
    end else begin : g_off
      assign states[i] = 1'b0;
    end
  end

  assign last    = tok_link[cfrem_pkg::RULES];
  assign dl_new  = last.rise ? now_hold + {16'd0, timeout} : deadline;
  assign eng_new = (last.rise || engaged) && !(now_hold > dl_new);
  assign load    = (state == ST_FINISH) && (!res_valid || res_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req_data.opcode == cfrem_pkg::OP_FRAME ||
                        req_data.opcode == cfrem_pkg::OP_POLL) ? ST_RUN : ST_FINISH;
        end
      end
      ST_RUN: begin
        if (last.valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rule_count <= 5'd0;
      timeout    <= cfrem_pkg::TIMEOUT_RESET;
      engaged    <= 1'b0;
      deadline   <= 32'd0;
      ev_valid   <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == cfrem_pkg::CFG_RULE_COUNT) begin
        rule_count <= cfg_data[4:0];
      end
      if (cfg_we && cfg_index == cfrem_pkg::CFG_TIMEOUT) begin
        timeout <= cfg_data;
      end
      if (accept) begin
        ev_valid <= 1'b0;
      end
      if (state == ST_RUN && last.valid) begin
        if (last.is_poll) begin
          ev_valid <= last.found;
        end else begin
          engaged  <= eng_new;
          deadline <= dl_new;
        end
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_hold <= req_data.now_ms;
    end
    if (state == ST_RUN && last.valid) begin
      ev_rule <= last.found ? last.found_rule : '0;
    end
    if (load) begin
      res_data.engaged      <= engaged;
      res_data.event_valid  <= ev_valid;
      res_data.event_rule   <= ev_valid ? 4'(ev_rule) : 4'd0;
      res_data.match_states <= states;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_busy) <= 1)
    else $error("more than one token in rule chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> tok_busy == '0)
    else $error("token in chain while idle");

  a_exit_in_run: assert property (@(posedge clk) disable iff (rst)
    last.valid |-> state == ST_RUN)
    else $error("token left chain outside run");

  a_write_finish: assert property (@(posedge clk) disable iff (rst)
    accept && (req_data.opcode == cfrem_pkg::OP_HDR ||
               req_data.opcode == cfrem_pkg::OP_COND) |=> state == ST_FINISH)
    else $error("write request did not finish at once");

  a_res_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside finish");

endmodule
